// ===== rtl/tdpt_pkg.sv =====
// Shared types and constants of the trial-division prime tester.
`default_nettype none

package tdpt_pkg;

   // Port field widths, fixed by the interface
   localparam int FIELD_WIDTH = 64;

   // Divisor sequence of the 6k +/- 1 search
   localparam int PRIME_TWO  = 2;
   localparam int PRIME_PRE  = 3;
   localparam int DIV_START  = 5;
   localparam int DIV_STEP   = 6;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] value;
      logic                          is_last;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] value_out;
      logic                          prime;
      logic                          last_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/trial_division_prime_test.sv =====
// Trial-division primality tester with a bit-serial remainder datapath.
//
// Usage: one request carries a signed number and a last-of-list mark; one
// response returns the number (sign-extended from VALUE_WIDTH bits), a prime
// flag and the mark. A request is taken when req_valid is high and req_stall
// low; a response leaves when rsp_valid is high and rsp_stall low.
// Negative numbers, 0, 1, 2, 3 and even numbers finish without a remainder
// pass. Other numbers first get a remainder pass by 3, then one pass per
// divisor pair (i, i+2), i = 5, 11, 17, ... while i*i <= n. Each pass
// shifts the number through two restoring remainder units one bit per
// cycle; a prime n runs through every pass while i*i <= n, and a
// composite stops at the pass that finds its smallest factor.
// One request is in work at a time; req_stall is high until its result has
// moved into the output register, which holds it while rsp_stall is high,
// so the next request can be taken while a result still waits.
// Reset (synchronous, active high) drops any request in work and empties
// the output register.
`default_nettype none

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   localparam int DW  = VALUE_WIDTH / 2 + 2;
   localparam int SQW = 2 * DW;
   localparam int CW  = $clog2(VALUE_WIDTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TEST = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EVAL = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   fin_ff, fin_in;
   logic                   first_ff, first_in;
   logic                   res_prime_ff, res_prime_in;
   logic signed [VALUE_WIDTH-1:0] num_ff, num_in;
   logic                   last_ff, last_in;
   logic [VALUE_WIDTH-1:0] sh_ff, sh_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [DW-1:0]          i_ff, i_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic [DW-1:0]          div_a_ff, div_a_in;
   logic [DW-1:0]          div_b_ff, div_b_in;
   logic [DW-1:0]          rem_a_ff, rem_a_in;
   logic [DW-1:0]          rem_b_ff, rem_b_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [VALUE_WIDTH-1:0] req_num;
   logic                   req_take;
   logic                   out_free;
   logic [DW:0]            part_a, part_b;
   logic [DW-1:0]          step_a, step_b;

   assign req_num   = req_data.value[VALUE_WIDTH-1:0];
   assign req_stall = (state_ff != ST_IDLE) || fin_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // One restoring step per unit: bring in the next bit, subtract if it fits
   always_comb begin
      part_a = {rem_a_ff, sh_ff[VALUE_WIDTH-1]};
      part_b = {rem_b_ff, sh_ff[VALUE_WIDTH-1]};
      if (part_a >= {1'b0, div_a_ff}) begin
         step_a = DW'(part_a - {1'b0, div_a_ff});
      end else begin
         step_a = DW'(part_a);
      end
      if (part_b >= {1'b0, div_b_ff}) begin
         step_b = DW'(part_b - {1'b0, div_b_ff});
      end else begin
         step_b = DW'(part_b);
      end
   end

   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      first_in     = first_ff;
      res_prime_in = res_prime_ff;
      num_in       = num_ff;
      last_in      = last_ff;
      sh_in        = sh_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      sq_in        = sq_ff;
      div_a_in     = div_a_ff;
      div_b_in     = div_b_ff;
      rem_a_in     = rem_a_ff;
      rem_b_in     = rem_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // Hand a finished result to the output register once it is free
      if (fin_ff && out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_out = FIELD_WIDTH'(num_ff);
         rsp_data_in.prime     = res_prime_ff;
         rsp_data_in.last_out  = last_ff;
         fin_in                = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               num_in   = req_num;
               last_in  = req_data.is_last;
               sh_in    = req_num;
               cnt_in   = '0;
               rem_a_in = '0;
               rem_b_in = '0;
               div_a_in = DW'(PRIME_PRE);
               div_b_in = DW'(PRIME_PRE);
               first_in = 1'b1;
               priority if (req_num[VALUE_WIDTH-1] || req_num[VALUE_WIDTH-1:1] == '0) begin
                  res_prime_in = 1'b0;
                  fin_in       = 1'b1;
               end else if (req_num == VALUE_WIDTH'(PRIME_TWO) ||
                            req_num == VALUE_WIDTH'(PRIME_PRE)) begin
                  res_prime_in = 1'b1;
                  fin_in       = 1'b1;
               end else if (!req_num[0]) begin
                  res_prime_in = 1'b0;
                  fin_in       = 1'b1;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_TEST: begin
            // Stop the search once i*i passes n
            if (SQW'(unsigned'(num_ff)) < sq_ff) begin
               res_prime_in = 1'b1;
               fin_in       = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               div_a_in = i_ff;
               div_b_in = i_ff + DW'(PRIME_TWO);
               sh_in    = num_ff;
               cnt_in   = '0;
               rem_a_in = '0;
               rem_b_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_a_in = step_a;
            rem_b_in = step_b;
            sh_in    = {sh_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CW'(VALUE_WIDTH - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rem_a_ff == '0 || rem_b_ff == '0) begin
               res_prime_in = 1'b0;
               fin_in       = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_TEST;
               if (first_ff) begin
                  first_in = 1'b0;
                  i_in     = DW'(DIV_START);
                  sq_in    = SQW'(DIV_START * DIV_START);
               end else begin
                  // (i+6)^2 = i^2 + 12i + 36
                  i_in  = i_ff + DW'(DIV_STEP);
                  sq_in = sq_ff + SQW'(i_ff) * SQW'(2 * DIV_STEP)
                          + SQW'(DIV_STEP * DIV_STEP);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      res_prime_ff <= res_prime_in;
      num_ff       <= num_in;
      last_ff      <= last_in;
      sh_ff        <= sh_in;
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      sq_ff        <= sq_in;
      div_a_ff     <= div_a_in;
      div_b_ff     <= div_b_in;
      rem_a_ff     <= rem_a_in;
      rem_b_ff     <= rem_b_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Final remainders are below their divisors when the serial pass ends
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (rem_a_ff < div_a_ff && rem_b_ff < div_b_ff))
      else $error("remainder not below divisor");

   // Trial divisors are always odd
   a_div_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_a_ff[0] && div_b_ff[0]))
      else $error("even trial divisor");

   // A new result enters the output register only from a finished search
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(fin_ff))
      else $error("result loaded without a finished search");

   // A reported prime is non-negative and odd, or two
   a_prime_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.prime) |->
      (!rsp_data_ff.value_out[FIELD_WIDTH-1] &&
       (rsp_data_ff.value_out[0] || rsp_data_ff.value_out == FIELD_WIDTH'(PRIME_TWO))))
      else $error("prime flag on negative or even number");

endmodule

`default_nettype wire
